@@ rtl/fixed_block_fit_allocator_top_macros.svh @@
// Assertion macros shared by the fixed-block fit allocator RTL.
`ifndef FIXED_BLOCK_FIT_ALLOCATOR_TOP_MACROS_SVH
`define FIXED_BLOCK_FIT_ALLOCATOR_TOP_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define FBFA_ASSERT_NOW(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Checks that a condition follows from a trigger in the next cycle.
`define FBFA_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/fbfa_pkg.sv @@
// Package with shared types and constants of the fixed-block fit allocator.
`timescale 1ns / 1ps
package fbfa_pkg;

   localparam int NUM_BLOCKS_DEF = 16;
   localparam int SIZE_BITS_DEF  = 16;
   localparam int AMOUNT_W       = 16;
   localparam int BLOCK_INDEX_W  = 4;
   localparam int BLOCK_NUM_W    = 5;
   localparam int POLICY_W       = 2;
   localparam int BIU_W          = 5;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 5;
   localparam int CELL_ID_W      = 9;

   localparam logic [BIU_W-1:0] BIU_RESET = BIU_W'(16);

   typedef enum logic [POLICY_W-1:0] {
      POLICY_FIRST = 2'd0,
      POLICY_WORST = 2'd1,
      POLICY_BEST  = 2'd2
   } policy_type;

   typedef enum logic [0:0] {
      MODE_LOAD    = 1'b0,
      MODE_REQUEST = 1'b1
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIT_POLICY    = 1'b0,
      CSR_BLOCKS_IN_USE = 1'b1
   } csr_index_type;

   typedef struct packed {
      mode_type                 mode;
      logic [BLOCK_INDEX_W-1:0] block_index;
      logic [AMOUNT_W-1:0]      amount;
   } req_type;

   typedef struct packed {
      logic                   allocated;
      logic [BLOCK_NUM_W-1:0] block_number;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic found;
   } link_type;

   typedef struct packed {
      logic load;
      logic update;
   } cmd_type;

endpackage

@@ rtl/fixed_block_fit_allocator_top.sv @@
// Top level of the fixed-block fit allocator: control, configuration and the cell chain.
`timescale 1ns / 1ps
`include "fixed_block_fit_allocator_top_macros.svh"
// The allocator keeps one capacity per block in a chain of NUM_BLOCKS cells. A load
// transaction writes one capacity in the cycle it is accepted, and the next transaction
// can follow at once. In a request transaction the search record passes one cell per clock
// along the chain; a finish state then writes the response register and, for a granted
// request, the chosen block's new capacity. A response that is not taken holds the block
// in the finish state. Only one request is in flight at a time.
module fixed_block_fit_allocator_top #(
   parameter int NUM_BLOCKS = fbfa_pkg::NUM_BLOCKS_DEF,
   parameter int SIZE_BITS  = fbfa_pkg::SIZE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  fbfa_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output fbfa_pkg::rsp_type                  rsp_data,
   input  logic                               csr_wr_en,
   input  logic [fbfa_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fbfa_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import fbfa_pkg::*;

   localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int NUM_W  = IDX_W + 1;
   localparam int CMP_W  = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   state_type             state_ff;
   logic [POLICY_W-1:0]   policy_ff;
   logic [BIU_W-1:0]      biu_ff;
   logic [AMOUNT_W-1:0]   size_ff;
   logic                  grant_ff;
   logic [IDX_W-1:0]      grant_idx_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   logic                  req_fire;
   logic                  load_ok;
   logic                  out_free;
   logic                  found_fit;
   logic [NUM_W-1:0]      grant_num;
   cmd_type               cmd;
   logic [IDX_W-1:0]      bus_index;
   logic [AMOUNT_W-1:0]   bus_amount;

   link_type              link_w [0:NUM_BLOCKS];
   logic [SIZE_BITS-1:0]  cap_w  [0:NUM_BLOCKS];
   logic [IDX_W-1:0]      idx_w  [0:NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] chain_valid;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign load_ok   = (CELL_ID_W'(req_data.block_index) < CELL_ID_W'(NUM_BLOCKS));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign found_fit = link_w[NUM_BLOCKS].found &&
                      (CMP_W'(cap_w[NUM_BLOCKS]) >= CMP_W'(size_ff));
   assign grant_num = NUM_W'(grant_idx_ff) + NUM_W'(1);

   assign cmd.load   = req_fire && (req_data.mode == MODE_LOAD) && load_ok;
   assign cmd.update = (state_ff == ST_FINISH) && out_free && grant_ff;

   assign bus_index  = (state_ff == ST_IDLE) ? IDX_W'(req_data.block_index) : grant_idx_ff;
   assign bus_amount = (state_ff == ST_IDLE) ? req_data.amount : size_ff;

   assign link_w[0].valid = req_fire && (req_data.mode == MODE_REQUEST);
   assign link_w[0].found = 1'b0;
   assign cap_w[0]        = '0;
   assign idx_w[0]        = '0;

   for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
      fbfa_cell #(
         .SIZE_BITS (SIZE_BITS),
         .IDX_W     (IDX_W),
         .CELL_ID   (g)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd           (cmd),
         .bus_index     (bus_index),
         .bus_amount    (bus_amount),
         .fit_policy    (policy_ff),
         .blocks_in_use (biu_ff),
         .prev_link     (link_w[g]),
         .prev_cap      (cap_w[g]),
         .prev_idx      (idx_w[g]),
         .link_out      (link_w[g+1]),
         .cap_out       (cap_w[g+1]),
         .idx_out       (idx_w[g+1])
      );
      assign chain_valid[g] = link_w[g+1].valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_FIRST;
         biu_ff    <= BIU_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FIT_POLICY:    policy_ff <= POLICY_W'(csr_wdata);
            CSR_BLOCKS_IN_USE: biu_ff    <= csr_wdata;
            default:           biu_ff    <= biu_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         grant_ff     <= 1'b0;
      end else begin
         if ((state_ff == ST_FINISH) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && (req_data.mode == MODE_REQUEST)) begin
                  size_ff  <= req_data.amount;
                  state_ff <= ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               if (link_w[NUM_BLOCKS].valid) begin
                  grant_ff     <= found_fit;
                  grant_idx_ff <= idx_w[NUM_BLOCKS];
                  state_ff     <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_data_ff.allocated    <= grant_ff;
                  rsp_data_ff.block_number <= grant_ff ? BLOCK_NUM_W'(grant_num) : '0;
                  state_ff                 <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `FBFA_ASSERT_NOW(a_one_search, $onehot0(chain_valid), "more than one search in the chain")
   `FBFA_ASSERT_NOW(a_end_in_search, !chain_valid[NUM_BLOCKS-1] || (state_ff == ST_SEARCH), "search ended outside the search state")
   `FBFA_ASSERT_NEXT(a_search_start, link_w[0].valid, chain_valid[0], "request did not enter the first cell")
   `FBFA_ASSERT_NEXT(a_update_rsp, cmd.update, rsp_valid_ff && rsp_data_ff.allocated, "capacity update without a granted response")

endmodule

@@ rtl/fbfa_cell.sv @@
// One allocator cell: holds a block capacity and passes the search record onward.
`timescale 1ns / 1ps
module fbfa_cell #(
   parameter int SIZE_BITS = fbfa_pkg::SIZE_BITS_DEF,
   parameter int IDX_W     = 4,
   parameter int CELL_ID   = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  fbfa_pkg::cmd_type                cmd,
   input  logic [IDX_W-1:0]                 bus_index,
   input  logic [fbfa_pkg::AMOUNT_W-1:0]    bus_amount,
   input  logic [fbfa_pkg::POLICY_W-1:0]    fit_policy,
   input  logic [fbfa_pkg::BIU_W-1:0]       blocks_in_use,
   input  fbfa_pkg::link_type               prev_link,
   input  logic [SIZE_BITS-1:0]             prev_cap,
   input  logic [IDX_W-1:0]                 prev_idx,
   output fbfa_pkg::link_type               link_out,
   output logic [SIZE_BITS-1:0]             cap_out,
   output logic [IDX_W-1:0]                 idx_out
);
   import fbfa_pkg::*;

   localparam int CMP_W = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;
   localparam logic [CELL_ID_W-1:0] ID_WIDE  = CELL_ID_W'(CELL_ID);
   localparam logic [IDX_W-1:0]     ID_SHORT = IDX_W'(CELL_ID);

   logic [SIZE_BITS-1:0] cap_ff;
   logic [SIZE_BITS-1:0] cap_in;
   link_type             link_ff;
   logic [SIZE_BITS-1:0] best_cap_ff;
   logic [IDX_W-1:0]     best_idx_ff;
   logic                 selected;
   logic                 active;
   logic                 fits;
   logic                 take;
   logic                 capture;

   assign selected = (bus_index == ID_SHORT);
   assign active   = (ID_WIDE < CELL_ID_W'(blocks_in_use));
   assign fits     = (CMP_W'(cap_ff) >= CMP_W'(bus_amount));
   assign capture  = prev_link.valid && active && take;

   always_comb begin
      take = 1'b0;
      case (fit_policy)
         POLICY_WORST: take = !prev_link.found || (cap_ff >= prev_cap);
         POLICY_BEST:  take = fits && (!prev_link.found || (cap_ff <= prev_cap));
         default:      take = fits && !prev_link.found;
      endcase
   end

   always_comb begin
      cap_in = cap_ff;
      if (cmd.load && selected) begin
         cap_in = SIZE_BITS'(bus_amount);
      end else if (cmd.update && selected) begin
         cap_in = cap_ff - SIZE_BITS'(bus_amount);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= '0;
         link_ff <= '0;
      end else begin
         cap_ff        <= cap_in;
         link_ff.valid <= prev_link.valid;
         link_ff.found <= prev_link.found || capture;
      end
   end

   always_ff @(posedge clock) begin
      best_cap_ff <= capture ? cap_ff : prev_cap;
      best_idx_ff <= capture ? ID_SHORT : prev_idx;
   end

   assign link_out = link_ff;
   assign cap_out  = best_cap_ff;
   assign idx_out  = best_idx_ff;

endmodule

@@ bench/tb_fixed_block_fit_allocator_top.sv @@
// Self-checking testbench for the fixed-block fit allocator top level.
`timescale 1ns / 1ps
module tb_fixed_block_fit_allocator_top;
   import fbfa_pkg::*;

   localparam logic [POLICY_W-1:0] POLICY_RESERVED = 2'd3;
   localparam int LAST_PHASE = 11;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_FIT_POLICY;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   req_type pending_reqs[$];
   rsp_type expected_grants[$];
   int      reqs_queued = 0;
   int      reqs_accepted = 0;
   int      mismatch_count = 0;
   int      send_gap_max = 15;
   int      take_stall_max = 15;
   int      send_wait = 0;
   int      take_wait = 0;

   logic [POLICY_W-1:0]      model_policy = POLICY_FIRST;
   logic [BIU_W-1:0]         model_blocks = BIU_RESET;
   logic [SIZE_BITS_DEF-1:0] model_capacity[NUM_BLOCKS_DEF] = '{default: '0};

   fixed_block_fit_allocator_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   // Applies one accepted transaction to the capacity table and, for a request, queues its grant.
   function automatic void predict_allocation(input req_type item);
      int      searched;
      int      pick;
      logic    found;
      rsp_type grant;
      if (item.mode == MODE_LOAD) begin
         model_capacity[item.block_index] = item.amount;
         return;
      end
      searched = (model_blocks > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(model_blocks);
      found = 1'b0;
      pick = 0;
      for (int j = 0; j < searched; j++) begin
         if (model_policy == POLICY_WORST) begin
            if (!found || model_capacity[j] >= model_capacity[pick]) begin
               pick = j;
               found = 1'b1;
            end
         end else if (model_policy == POLICY_BEST) begin
            if (model_capacity[j] >= item.amount &&
                (!found || model_capacity[j] <= model_capacity[pick])) begin
               pick = j;
               found = 1'b1;
            end
         end else if (!found && model_capacity[j] >= item.amount) begin
            pick = j;
            found = 1'b1;
         end
      end
      if (found && model_capacity[pick] >= item.amount) begin
         model_capacity[pick] = model_capacity[pick] - item.amount;
         grant.allocated = 1'b1;
         grant.block_number = BLOCK_NUM_W'(pick + 1);
      end else begin
         grant = '0;
      end
      expected_grants.push_back(grant);
   endfunction

   task automatic push_item(input mode_type m, input int idx, input int amount);
      req_type item;
      item.mode = m;
      item.block_index = BLOCK_INDEX_W'(idx);
      item.amount = AMOUNT_W'(amount);
      pending_reqs.push_back(item);
      reqs_queued++;
   endtask

   task automatic drain();
      while (reqs_accepted != reqs_queued || expected_grants.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input int value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_FIT_POLICY)
         model_policy = POLICY_W'(value);
      else
         model_blocks = BIU_W'(value);
   endtask

   task automatic set_config(input int policy, input int blocks);
      drain();
      write_csr(CSR_FIT_POLICY, policy);
      write_csr(CSR_BLOCKS_IN_USE, blocks);
   endtask

   task automatic push_random_item();
      int pick;
      int sel;
      pick = $urandom_range(0, 99);
      sel = $urandom_range(0, 7);
      if (pick < 35) begin
         case (sel)
            0: push_item(MODE_LOAD, $urandom_range(0, 15), 16'hFFFF);
            1: push_item(MODE_LOAD, $urandom_range(0, 15), 0);
            2: push_item(MODE_LOAD, $urandom_range(0, 15), $urandom);
            default: push_item(MODE_LOAD, $urandom_range(0, 15), $urandom_range(1, 4000));
         endcase
      end else begin
         case (sel)
            0: push_item(MODE_REQUEST, $urandom_range(0, 15), 0);
            1: push_item(MODE_REQUEST, $urandom_range(0, 15), 16'hFFFF);
            2: push_item(MODE_REQUEST, $urandom_range(0, 15), $urandom);
            default: push_item(MODE_REQUEST, $urandom_range(0, 15), $urandom_range(1, 600));
         endcase
      end
   endtask

   always @(posedge clock) begin : request_driver
      logic holding;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         holding = req_valid && !req_ready;
         if (req_valid && req_ready) begin
            predict_allocation(req_data);
            reqs_accepted++;
            send_wait = $urandom_range(0, send_gap_max);
         end
         if (!holding) begin
            if (send_wait == 0 && pending_reqs.size() != 0) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
               if (send_wait > 0)
                  send_wait--;
            end
         end
      end
   end

   always @(posedge clock) begin : grant_monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         take_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_grants.size() == 0) begin
               report_mismatch($sformatf("response %0d/%0d with no request pending",
                  rsp_data.allocated, rsp_data.block_number));
            end else begin
               want = expected_grants.pop_front();
               if (rsp_data.allocated !== want.allocated)
                  report_mismatch($sformatf("allocated %0d, expected %0d",
                     rsp_data.allocated, want.allocated));
               if (rsp_data.block_number !== want.block_number)
                  report_mismatch($sformatf("block_number %0d, expected %0d",
                     rsp_data.block_number, want.block_number));
            end
            take_wait = $urandom_range(0, take_stall_max);
         end
         if (take_wait > 0) begin
            rsp_ready <= 1'b0;
            take_wait--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int phase_blocks[LAST_PHASE + 1];
      phase_blocks = '{16, 16, 1, 31, 8, 17, 0, 16, 2, 15, 16, 24};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed transactions: reset setup (first fit, all blocks), then other configurations.
      push_item(MODE_REQUEST, 0, 0);
      push_item(MODE_REQUEST, 15, 16'hFFFF);
      push_item(MODE_LOAD, 0, 16'hFFFF);
      push_item(MODE_LOAD, 15, 16'hFFFF);
      push_item(MODE_LOAD, 7, 100);
      push_item(MODE_REQUEST, 0, 16'hFFFF);
      push_item(MODE_REQUEST, 0, 50);
      set_config(POLICY_WORST, 16);
      push_item(MODE_REQUEST, 0, 10);
      push_item(MODE_LOAD, 3, 16'hFFF5);
      push_item(MODE_REQUEST, 0, 5);
      push_item(MODE_REQUEST, 0, 16'hFFFF);
      set_config(POLICY_BEST, 16);
      push_item(MODE_REQUEST, 0, 50);
      push_item(MODE_REQUEST, 0, 0);
      set_config(POLICY_RESERVED, 16);
      push_item(MODE_REQUEST, 0, 1);
      set_config(POLICY_FIRST, 0);
      push_item(MODE_REQUEST, 0, 0);
      set_config(POLICY_WORST, 31);
      push_item(MODE_REQUEST, 0, 1);
      set_config(POLICY_BEST, 1);
      push_item(MODE_REQUEST, 0, 0);
      push_item(MODE_REQUEST, 0, 1);

      for (int p = 0; p <= LAST_PHASE; p++) begin
         set_config(p % 4, phase_blocks[p]);
         send_gap_max = (p % 3 == 2) ? 0 : 15;
         take_stall_max = (p % 3 == 2) ? 0 : 15;
         for (int b = 0; b < NUM_BLOCKS_DEF; b++)
            push_item(MODE_LOAD, b, $urandom_range(0, 8000));
         repeat (140) push_random_item();
      end

      drain();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0)
         $display("fixed_block_fit_allocator_top regression: pass");
      else
         $display("fixed_block_fit_allocator_top regression: fail");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("fixed_block_fit_allocator_top regression: fail");
      $finish;
   end

endmodule
